FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cons must hold in the same cycle as ante
`define HES_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define HES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// cond must never be true
`define HES_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define HES_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define HES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define HES_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/hes_pkg.sv
// ----------------------------------------------------------------------------
// hes_pkg
// Widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hes_pkg;

	localparam int DATA_W    = 32;
	localparam int RATIO_W   = 16;
	localparam int STEP_W    = 16;
	localparam int LEN_W     = 7;
	localparam int INDEX_W   = 6;
	localparam int CFG_IDX_W = 2;

	// arithmetic widths
	localparam int SUM_W    = DATA_W + 1;          // left + right
	localparam int WEIGHT_W = RATIO_W + 2;         // signed 1 - 2r, up to 1.0
	localparam int PROD_W   = SUM_W + RATIO_W + 1;
	localparam int ACC_W    = PROD_W + 1;
	localparam int Q_W      = ACC_W - RATIO_W;

	localparam logic [RATIO_W-1:0] RATIO_CAP = 16'h8000;
	localparam logic [RATIO_W:0]   RATIO_ONE = 17'h1_0000;
	localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(RATIO_CAP);

	localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

	// drain between the last read of a sweep and the next access
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic               load_we;
		logic [INDEX_W-1:0] load_addr;
		logic               rd_en;
		logic               rd_sweep;
		logic               rd_emit;
		logic               rd_last;
		logic [INDEX_W-1:0] rd_addr;
	} hes_cmd_t;

	typedef struct packed {
		logic emit_slot_free;
		logic out_last_taken;
	} hes_status_t;

endpackage

FILE: rtl/hes_ram.sv
// ----------------------------------------------------------------------------
// hes_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/hes_ctrl.sv
// ----------------------------------------------------------------------------
// hes_ctrl
// Sequencer: load, sweep passes with pipeline drain, then read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hes_ctrl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        last_sample,
	input  logic [hes_pkg::STEP_W-1:0]  step_count,
	input  logic [hes_pkg::LEN_W-1:0]   grid_length,
	output hes_pkg::hes_cmd_t           cmd,
	input  hes_pkg::hes_status_t        status
);

	localparam int DRAIN_W = $clog2(hes_pkg::DRAIN_CYCLES);
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(hes_pkg::DRAIN_CYCLES - 1);
	localparam logic [hes_pkg::LEN_W-1:0] MAX_LEN = hes_pkg::LEN_W'(MAX_POINTS);

	typedef enum logic [2:0] {
		S_LOAD,
		S_SWEEP,
		S_DRAIN,
		S_EMIT,
		S_WAIT
	} state_t;

	state_t                      state_q;
	logic [hes_pkg::LEN_W-1:0]   load_pos_q;
	logic [hes_pkg::LEN_W-1:0]   idx_q;
	logic [hes_pkg::STEP_W-1:0]  step_q;
	logic [DRAIN_W-1:0]          drain_q;

	logic [hes_pkg::LEN_W-1:0]   len;
	logic [hes_pkg::LEN_W-1:0]   len_last;
	logic                        in_accept;
	logic                        at_end;

	assign len       = (grid_length > MAX_LEN) ? MAX_LEN : grid_length;
	assign len_last  = len - hes_pkg::LEN_W'(1);
	assign in_ready  = (state_q == S_LOAD);
	assign in_accept = in_valid && in_ready;
	assign at_end    = (idx_q == len_last);

	always_comb begin
		cmd           = '0;
		cmd.load_we   = in_accept && (load_pos_q < MAX_LEN);
		cmd.load_addr = load_pos_q[hes_pkg::INDEX_W-1:0];
		cmd.rd_sweep  = (state_q == S_SWEEP);
		cmd.rd_emit   = (state_q == S_EMIT) && status.emit_slot_free;
		cmd.rd_en     = cmd.rd_sweep || cmd.rd_emit;
		cmd.rd_last   = at_end;
		cmd.rd_addr   = idx_q[hes_pkg::INDEX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_pos_q <= '0;
			idx_q      <= '0;
			step_q     <= '0;
			drain_q    <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_accept) begin
						if (last_sample) begin
							load_pos_q <= '0;
							idx_q      <= '0;
							step_q     <= step_count;
							if (len == '0) begin
								state_q <= S_LOAD;
							end else if (len >= hes_pkg::LEN_W'(3) && step_count != '0) begin
								state_q <= S_SWEEP;
							end else begin
								state_q <= S_EMIT;
							end
						end else if (cmd.load_we) begin
							load_pos_q <= load_pos_q + hes_pkg::LEN_W'(1);
						end
					end
				end
				S_SWEEP: begin
					if (at_end) begin
						idx_q   <= '0;
						drain_q <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + hes_pkg::LEN_W'(1);
					end
				end
				S_DRAIN: begin
					// let the last writes of the pass land before reading again
					if (drain_q == DRAIN_LAST) begin
						step_q <= step_q - hes_pkg::STEP_W'(1);
						if (step_q == hes_pkg::STEP_W'(1)) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SWEEP;
						end
					end else begin
						drain_q <= drain_q + DRAIN_W'(1);
					end
				end
				S_EMIT: begin
					if (status.emit_slot_free) begin
						if (at_end) begin
							state_q <= S_WAIT;
						end else begin
							idx_q <= idx_q + hes_pkg::LEN_W'(1);
						end
					end
				end
				S_WAIT: begin
					if (status.out_last_taken) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: rtl/hes_datapath.sv
// ----------------------------------------------------------------------------
// hes_datapath
// Grid store, three-point window, stencil pipeline and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hes_datapath #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hes_pkg::hes_cmd_t                   cmd,
	output hes_pkg::hes_status_t                status,
	input  logic signed [hes_pkg::DATA_W-1:0]   sample_value,
	input  logic [hes_pkg::RATIO_W-1:0]         ratio,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [hes_pkg::INDEX_W-1:0]         point_index,
	output logic signed [hes_pkg::DATA_W-1:0]   point_value,
	output logic                                last_point
);

	localparam int ADDR_W = $clog2(MAX_POINTS);

	// grid store
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [hes_pkg::DATA_W-1:0]   ram_wdata;
	logic [hes_pkg::DATA_W-1:0]   ram_rdata;
	logic signed [hes_pkg::DATA_W-1:0] rd_sgn;

	// window and pipeline
	logic                                rvld_q;
	logic [hes_pkg::INDEX_W-1:0]         ridx_q;
	logic signed [hes_pkg::DATA_W-1:0]   prev1_q;
	logic signed [hes_pkg::DATA_W-1:0]   prev2_q;

	logic                                vld_s1;
	logic [hes_pkg::INDEX_W-1:0]         idx_s1;
	logic signed [hes_pkg::SUM_W-1:0]    sum_s1;
	logic signed [hes_pkg::DATA_W-1:0]   centre_s1;

	logic                                vld_s2;
	logic [hes_pkg::INDEX_W-1:0]         idx_s2;
	logic signed [hes_pkg::PROD_W-1:0]   side_s2;
	logic signed [hes_pkg::PROD_W-1:0]   mid_s2;

	logic                                vld_s3;
	logic [hes_pkg::INDEX_W-1:0]         idx_s3;
	logic signed [hes_pkg::DATA_W-1:0]   res_s3;

	logic [hes_pkg::RATIO_W:0]           weight;
	logic signed [hes_pkg::WEIGHT_W-1:0] weight_sgn;
	logic signed [hes_pkg::RATIO_W:0]    ratio_sgn;
	logic signed [hes_pkg::PROD_W-1:0]   side_prod;
	logic signed [hes_pkg::PROD_W-1:0]   mid_prod;
	logic [hes_pkg::ACC_W-1:0]           acc;
	logic signed [hes_pkg::Q_W-1:0]      quot;
	logic signed [hes_pkg::DATA_W-1:0]   sat;

	// read-out
	logic                                emit_pend_q;
	logic [hes_pkg::INDEX_W-1:0]         emit_idx_q;
	logic                                emit_last_q;
	logic                                move;
	logic                                out_valid_q;
	logic [hes_pkg::INDEX_W-1:0]         out_index_q;
	logic [hes_pkg::DATA_W-1:0]          out_value_q;
	logic                                out_last_q;

	assign ram_we    = cmd.load_we || vld_s3;
	assign ram_waddr = cmd.load_we ? cmd.load_addr[ADDR_W-1:0] : idx_s3[ADDR_W-1:0];
	assign ram_wdata = cmd.load_we ? sample_value : res_s3;
	assign rd_sgn    = signed'(ram_rdata);

	hes_ram #(
		.WIDTH (hes_pkg::DATA_W),
		.DEPTH (MAX_POINTS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// r*(left + right) + (1 - 2r)*centre, rounded half up, saturated
	assign weight     = hes_pkg::RATIO_ONE - {ratio, 1'b0};
	assign weight_sgn = signed'({1'b0, weight});
	assign ratio_sgn  = signed'({1'b0, ratio});
	assign side_prod  = hes_pkg::PROD_W'(sum_s1) * hes_pkg::PROD_W'(ratio_sgn);
	assign mid_prod   = hes_pkg::PROD_W'(centre_s1) * hes_pkg::PROD_W'(weight_sgn);

	assign acc  = hes_pkg::ACC_W'(side_s2) + hes_pkg::ACC_W'(mid_s2) + hes_pkg::ROUND_HALF;
	assign quot = signed'(acc[hes_pkg::ACC_W-1:hes_pkg::RATIO_W]);

	always_comb begin
		if (&quot[hes_pkg::Q_W-1:hes_pkg::DATA_W-1] || ~|quot[hes_pkg::Q_W-1:hes_pkg::DATA_W-1]) begin
			sat = quot[hes_pkg::DATA_W-1:0];
		end else if (quot[hes_pkg::Q_W-1]) begin
			sat = {1'b1, {(hes_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(hes_pkg::DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			rvld_q <= cmd.rd_en && cmd.rd_sweep;
			// a new value only exists once both neighbours have been read
			vld_s1 <= rvld_q && (ridx_q >= hes_pkg::INDEX_W'(2));
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			ridx_q <= cmd.rd_addr;
		end
		if (rvld_q) begin
			prev1_q <= rd_sgn;
			prev2_q <= prev1_q;
		end
		sum_s1    <= hes_pkg::SUM_W'(prev2_q) + hes_pkg::SUM_W'(rd_sgn);
		centre_s1 <= prev1_q;
		idx_s1    <= ridx_q - hes_pkg::INDEX_W'(1);
		side_s2   <= side_prod;
		mid_s2    <= mid_prod;
		idx_s2    <= idx_s1;
		res_s3    <= sat;
		idx_s3    <= idx_s2;
	end

	// read data register acts as a stage ahead of the output word
	assign move = emit_pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_emit) begin
				emit_pend_q <= 1'b1;
			end else if (move) begin
				emit_pend_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_emit) begin
			emit_idx_q  <= cmd.rd_addr;
			emit_last_q <= cmd.rd_last;
		end
		if (move) begin
			out_index_q <= emit_idx_q;
			out_value_q <= ram_rdata;
			out_last_q  <= emit_last_q;
		end
	end

	assign status.emit_slot_free = !emit_pend_q || move;
	assign status.out_last_taken = out_valid_q && out_ready && out_last_q;

	assign out_valid   = out_valid_q;
	assign point_index = out_index_q;
	assign point_value = signed'(out_value_q);
	assign last_point  = out_last_q;

endmodule

FILE: rtl/heat_equation_stencil_1d.sv
// ----------------------------------------------------------------------------
// heat_equation_stencil_1d
// Explicit FTCS heat-equation solver over a 1-D fixed-point grid.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | sample_value, last_sample
//   out     | out       | out_valid/out_ready  | point_index, point_value, last_point
//
// Load takes one sample word a cycle; a grid length of zero emits nothing.
// After the last word, if L >= 3, each of step_count sweeps reads the grid once
// through the RAM read port: L points, then a pipeline drain.
// Read-out then gives one word a cycle while out_ready stays high.
// Reset clears control and sets the registers; the grid store is not cleared.
// in_ready stays low from the last sample until the last point is taken (L > 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module heat_equation_stencil_1d #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hes_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hes_pkg::STEP_W-1:0]           cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [hes_pkg::DATA_W-1:0]    sample_value,
	input  logic                                 last_sample,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hes_pkg::INDEX_W-1:0]          point_index,
	output logic signed [hes_pkg::DATA_W-1:0]    point_value,
	output logic                                 last_point
);

	logic [hes_pkg::RATIO_W-1:0] ratio_q;
	logic [hes_pkg::STEP_W-1:0]  steps_q;
	logic [hes_pkg::LEN_W-1:0]   length_q;
	logic [hes_pkg::RATIO_W-1:0] ratio_eff;
	logic                        out_take;

	hes_pkg::hes_cmd_t    cmd;
	hes_pkg::hes_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= hes_pkg::RATIO_CAP;
			steps_q  <= hes_pkg::STEP_W'(1);
			length_q <= hes_pkg::LEN_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hes_pkg::REG_RATIO:  ratio_q  <= cfg_data[hes_pkg::RATIO_W-1:0];
				hes_pkg::REG_STEPS:  steps_q  <= cfg_data[hes_pkg::STEP_W-1:0];
				hes_pkg::REG_LENGTH: length_q <= cfg_data[hes_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ratio above one half is held at one half
	assign ratio_eff = (ratio_q > hes_pkg::RATIO_CAP) ? hes_pkg::RATIO_CAP : ratio_q;

	hes_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_sample (last_sample),
		.step_count  (steps_q),
		.grid_length (length_q),
		.cmd         (cmd),
		.status      (status)
	);

	hes_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_value (sample_value),
		.ratio        (ratio_eff),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.point_index  (point_index),
		.point_value  (point_value),
		.last_point   (last_point)
	);

	assign out_take = out_valid && out_ready;

	`HES_ASSERT_NEVER(a_no_overlap, clk, arst_n, in_ready && out_valid, "load in read-out")
	`HES_ASSERT_NEXT(a_reopen, clk, arst_n, out_take && last_point, in_ready, "input still shut")
	`HES_ASSERT_NEXT(a_held_shut, clk, arst_n, out_take && !last_point, !in_ready, "early reopen")

endmodule
